FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the scan-rate mode controller RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Clocked check, disabled while reset is asserted
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Clocked check that also holds during reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_RST(label, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

FILE: rtl/core/rsrmc_pkg.sv
// Types, constants and the rate-policy table of the scan-rate mode controller.
// No dependencies.
`default_nettype none
package rsrmc_pkg;

    localparam int COUNT_W    = 8;
    localparam int TIME_W     = 48;
    localparam int DELAY_W    = 16;
    localparam int POLICY_W   = 13;
    localparam int MODE_W     = 3;
    localparam int APB_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_IDX_W  = CFG_ADDR_W - 2;

    localparam logic [DELAY_W-1:0]   DELAY_RESET    = 16'd5000;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_DELAY = 1'b0;

    typedef enum logic [MODE_W-1:0] {
        MODE_IDLE         = 3'd0,
        MODE_DETECTING    = 3'd1,
        MODE_TRACKING     = 3'd2,
        MODE_LOST_PENDING = 3'd3,
        MODE_LOST         = 3'd4
    } mode_t;

    // One update request as held in the input stage
    typedef struct packed {
        logic [COUNT_W-1:0] candidate_targets;
        logic [COUNT_W-1:0] active_targets;
        logic [COUNT_W-1:0] retained_targets;
        logic [TIME_W-1:0]  time_ms;
    } req_item_t;

    typedef struct packed {
        logic [POLICY_W-1:0] word_a;
        logic [POLICY_W-1:0] word_b;
        logic [POLICY_W-1:0] word_c;
        logic [POLICY_W-1:0] word_d;
        logic [POLICY_W-1:0] word_e;
    } policy_t;

    typedef struct packed {
        mode_t   rate_mode;
        logic    mode_changed;
        policy_t policy;
    } res_item_t;

    // Rate-policy words per mode; lost pending and lost share a row
    function automatic policy_t policy_row(input mode_t m);
        policy_t p;
        case (m)
            MODE_IDLE:      p = '{13'd100, 13'd200, 13'd1000, 13'd5000, 13'd0};
            MODE_DETECTING: p = '{13'd100, 13'd100, 13'd333,  13'd1000, 13'd200};
            MODE_TRACKING:  p = '{13'd50,  13'd67,  13'd200,  13'd1000, 13'd100};
            MODE_LOST_PENDING,
            MODE_LOST:      p = '{13'd100, 13'd200, 13'd333,  13'd1000, 13'd0};
            default:        p = '{13'd100, 13'd200, 13'd1000, 13'd5000, 13'd0};
        endcase
        return p;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/rsrmc_if.sv
// Request and result channel interfaces of the scan-rate mode controller.
// Depends on rsrmc_pkg for field widths.
`default_nettype none
interface rsrmc_req_if
    import rsrmc_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] candidate_targets;
    logic [COUNT_W-1:0] active_targets;
    logic [COUNT_W-1:0] retained_targets;
    logic [TIME_W-1:0]  time_ms;

    modport source (
        output valid, candidate_targets, active_targets, retained_targets, time_ms,
        input  ready
    );
    modport sink (
        input  valid, candidate_targets, active_targets, retained_targets, time_ms,
        output ready
    );
endinterface

interface rsrmc_res_if
    import rsrmc_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [MODE_W-1:0]   rate_mode;
    logic                mode_changed;
    logic [POLICY_W-1:0] policy_word_a;
    logic [POLICY_W-1:0] policy_word_b;
    logic [POLICY_W-1:0] policy_word_c;
    logic [POLICY_W-1:0] policy_word_d;
    logic [POLICY_W-1:0] policy_word_e;

    modport source (
        output valid, rate_mode, mode_changed,
               policy_word_a, policy_word_b, policy_word_c, policy_word_d, policy_word_e,
        input  ready
    );
    modport sink (
        input  valid, rate_mode, mode_changed,
               policy_word_a, policy_word_b, policy_word_c, policy_word_d, policy_word_e,
        output ready
    );
endinterface
`default_nettype wire

FILE: rtl/core/rsrmc_cfg.sv
// APB-style register block holding the idle delay.
// Depends on rsrmc_pkg.
`default_nettype none
module rsrmc_cfg
    import rsrmc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output logic      [DELAY_W-1:0]    idle_delay
);

    logic [DELAY_W-1:0]   delay_reg;
    logic [DELAY_W-1:0]   delay_next;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[CFG_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    // Write decode
    always_comb
    begin
        delay_next = delay_reg;
        if (wr_en && (reg_idx == REG_IDLE_DELAY))
        begin
            delay_next = pwdata[DELAY_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg <= DELAY_RESET;
        end
        else
        begin
            delay_reg <= delay_next;
        end
    end

    // Read mux
    always_comb
    begin
        prdata = '0;
        if (reg_idx == REG_IDLE_DELAY)
        begin
            prdata = {{(APB_DATA_W-DELAY_W){1'b0}}, delay_reg};
        end
    end

    assign idle_delay = delay_reg;

endmodule
`default_nettype wire

FILE: rtl/core/rsrmc_mode.sv
// Mode decision: state registers and the priority rules for one update.
// Depends on rsrmc_pkg.
`default_nettype none
module rsrmc_mode
    import rsrmc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               advance,
    input  wire req_item_t          item,
    input  wire logic [DELAY_W-1:0] idle_delay,
    output res_item_t               result
);

    mode_t             mode_reg, mode_next;
    logic [TIME_W-1:0] quiet_since_reg, quiet_since_next;
    logic              quiet_valid_reg, quiet_valid_next;
    logic              had_retained_reg, had_retained_next;

    logic [TIME_W-1:0] elapsed;
    logic [TIME_W-1:0] delay_ext;
    logic              backward;

    assign elapsed   = item.time_ms - quiet_since_reg;
    assign delay_ext = {{(TIME_W-DELAY_W){1'b0}}, idle_delay};
    assign backward  = item.time_ms < quiet_since_reg;

    // Priority rules
    always_comb
    begin
        mode_next        = mode_reg;
        quiet_since_next = quiet_since_reg;
        quiet_valid_next = quiet_valid_reg;
        if (item.active_targets != '0)
        begin
            quiet_valid_next = 1'b0;
            mode_next        = MODE_TRACKING;
        end
        else if (item.retained_targets != '0)
        begin
            quiet_valid_next = 1'b0;
            mode_next        = MODE_LOST_PENDING;
        end
        else if (had_retained_reg || (mode_reg == MODE_LOST_PENDING))
        begin
            // loss confirmed: start the quiet timer
            quiet_since_next = item.time_ms;
            quiet_valid_next = 1'b1;
            mode_next        = MODE_LOST;
        end
        else if (item.candidate_targets != '0)
        begin
            quiet_valid_next = 1'b0;
            mode_next        = MODE_DETECTING;
        end
        else if ((mode_reg == MODE_LOST) && quiet_valid_reg && !backward &&
                 (elapsed < delay_ext))
        begin
            // lost hold
            mode_next = mode_reg;
        end
        else if (!quiet_valid_reg || backward)
        begin
            // timer (re)starts now, so elapsed time is zero
            quiet_since_next = item.time_ms;
            quiet_valid_next = 1'b1;
            if (idle_delay == '0)
            begin
                mode_next = MODE_IDLE;
            end
        end
        else if (elapsed >= delay_ext)
        begin
            mode_next = MODE_IDLE;
        end
    end

    assign had_retained_next = (item.retained_targets != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= MODE_IDLE;
            quiet_since_reg  <= '0;
            quiet_valid_reg  <= 1'b0;
            had_retained_reg <= 1'b0;
        end
        else if (advance)
        begin
            mode_reg         <= mode_next;
            quiet_since_reg  <= quiet_since_next;
            quiet_valid_reg  <= quiet_valid_next;
            had_retained_reg <= had_retained_next;
        end
    end

    // Result for this update
    always_comb
    begin
        result.rate_mode    = mode_next;
        result.mode_changed = (mode_next != mode_reg);
        result.policy       = policy_row(mode_next);
    end

endmodule
`default_nettype wire

FILE: rtl/core/radar_scan_rate_mode_controller_core.sv
// Top level of the radar scan-rate mode controller: input stage, result stage,
// mode logic and register block. Depends on rsrmc_pkg, rsrmc_if, rsrmc_cfg,
// rsrmc_mode and assert_macros.svh.
//
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+--------------------------------------
//  req     | in  | valid/ready         | target counts, time_ms
//  res     | out | valid/ready         | rate_mode, mode_changed, 5 policy words
//  apb     | in  | psel/penable/pready | idle_delay_ms at address 0
//
// One request per cycle sustained while the result is not stalled. A request is
// taken into the input register, then decided and written to the result register
// once that register is free. The mode state updates as a request moves from
// the input to the result stage.
// A stalled result holds; the input stage still takes one request behind it.
// Reset puts the mode at idle with the quiet timer clear and delay 5000 ms.
`include "assert_macros.svh"
`default_nettype none
module radar_scan_rate_mode_controller_core
    import rsrmc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    rsrmc_req_if.sink                  req,
    rsrmc_res_if.source                res,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    logic         s1_valid_reg, s1_valid_next;
    req_item_t    s1_item_reg;
    logic         res_valid_reg, res_valid_next;
    res_item_t    res_item_reg;
    res_item_t    result;
    logic         out_free;
    logic         advance;
    logic         req_take;
    logic [DELAY_W-1:0] idle_delay;

    // Handshake
    assign out_free  = !res_valid_reg || res.ready;
    assign advance   = s1_valid_reg && out_free;
    assign req.ready = !s1_valid_reg || out_free;
    assign req_take  = req.valid && req.ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (req_take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (advance)
        begin
            res_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Input stage payload
    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            s1_item_reg.candidate_targets <= req.candidate_targets;
            s1_item_reg.active_targets    <= req.active_targets;
            s1_item_reg.retained_targets  <= req.retained_targets;
            s1_item_reg.time_ms           <= req.time_ms;
        end
    end

    // Result stage payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_item_reg <= result;
        end
    end

    rsrmc_cfg u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .idle_delay (idle_delay)
    );

    rsrmc_mode u_mode (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .item       (s1_item_reg),
        .idle_delay (idle_delay),
        .result     (result)
    );

    assign res.valid         = res_valid_reg;
    assign res.rate_mode     = res_item_reg.rate_mode;
    assign res.mode_changed  = res_item_reg.mode_changed;
    assign res.policy_word_a = res_item_reg.policy.word_a;
    assign res.policy_word_b = res_item_reg.policy.word_b;
    assign res.policy_word_c = res_item_reg.policy.word_c;
    assign res.policy_word_d = res_item_reg.policy.word_d;
    assign res.policy_word_e = res_item_reg.policy.word_e;

    // Checks
    `ASSERT_RST(a_no_overrun, clk, rst_n, (s1_valid_reg && res_valid_reg && !res.ready) |-> !req.ready, "request taken while both stages full")
    `ASSERT_RST(a_active_tracks, clk, rst_n, (advance && (s1_item_reg.active_targets != '0)) |=> (res.valid && (res.rate_mode == MODE_TRACKING)), "active targets did not give tracking")
    `ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |-> !res.valid, "result valid during reset")

endmodule
`default_nettype wire
